// File: hdl/nec_ir_pkg.sv
// Package for the NEC infrared pulse decoder: event codes, pulse-width windows,
// field widths and the timeout default. No dependencies.
`default_nettype none

package nec_ir_pkg;

   localparam int CMD_W     = 2;
   localparam int WIDTH_W   = 16;
   localparam int KEY_W     = 8;
   localparam int REPEAT_W  = 8;
   localparam int TIMEOUT_W = 4;
   localparam int FRAME_W   = 32;
   localparam int ADDR_W    = 8;

   localparam int TIMEOUT_LIMIT = 14;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK = 2'd0,
      CMD_RISE = 2'd1,
      CMD_FALL = 2'd2,
      CMD_SCAN = 2'd3
   } cmd_type;

   // Open windows on the measured high time, in microseconds.
   localparam logic [WIDTH_W-1:0] ZERO_LO   = 16'd300;
   localparam logic [WIDTH_W-1:0] ZERO_HI   = 16'd800;
   localparam logic [WIDTH_W-1:0] ONE_LO    = 16'd1400;
   localparam logic [WIDTH_W-1:0] ONE_HI    = 16'd1800;
   localparam logic [WIDTH_W-1:0] REPEAT_LO = 16'd2200;
   localparam logic [WIDTH_W-1:0] REPEAT_HI = 16'd2600;
   localparam logic [WIDTH_W-1:0] LEADER_LO = 16'd4200;
   localparam logic [WIDTH_W-1:0] LEADER_HI = 16'd4700;

endpackage

`default_nettype wire

// File: hdl/nec_ir_if.sv
// Valid/ready channel interfaces for the NEC infrared pulse decoder.
// Depends on nec_ir_pkg for the field widths.
`default_nettype none

interface nec_ir_req_if;
   logic                              valid;
   logic                              ready;
   logic [nec_ir_pkg::CMD_W-1:0]      cmd;
   logic [nec_ir_pkg::WIDTH_W-1:0]    pulse_width;

   modport source (output valid, output cmd, output pulse_width, input ready);
   modport sink   (input valid, input cmd, input pulse_width, output ready);
endinterface

interface nec_ir_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [nec_ir_pkg::KEY_W-1:0]      key_code;
   logic                              leader_seen;
   logic                              frame_ready;
   logic [nec_ir_pkg::REPEAT_W-1:0]   repeat_count;

   modport source (output valid, output key_code, output leader_seen,
                   output frame_ready, output repeat_count, input ready);
   modport sink   (input valid, input key_code, input leader_seen,
                   input frame_ready, input repeat_count, output ready);
endinterface

`default_nettype wire

// File: hdl/nec_ir_pulse_decoder.sv
// Top level of the NEC infrared pulse decoder: input register, decode logic,
// decoder state and result register. Depends on nec_ir_pkg and nec_ir_if.
//
//   Channel   Direction  Handshake          Payload
//   req_chan  in         valid/ready        cmd, pulse_width
//   rsp_chan  out        valid/ready        key_code, leader_seen, frame_ready,
//                                           repeat_count
//   csr_*     in         write enable only  device_address
//
// One transaction is accepted per cycle while the result channel does not stall;
// each passes through the input register and then the result register, with
// the whole state update done in one pass of logic between them.
// Reset clears the decoder state and both valid flags; the address register
// returns to zero. A stalled result holds the result register, and the input
// register then fills and holds until the result is taken.
`default_nettype none

module nec_ir_pulse_decoder #(
   parameter int TIMEOUT_LIMIT = nec_ir_pkg::TIMEOUT_LIMIT
) (
   input  wire                            clock,
   input  wire                            reset,
   nec_ir_req_if.sink                     req_chan,
   nec_ir_rsp_if.source                   rsp_chan,
   input  wire                            csr_wr_en,
   input  wire [nec_ir_pkg::ADDR_W-1:0]   csr_wr_data
);

   localparam logic [nec_ir_pkg::TIMEOUT_W-1:0] LIMIT_TICKS =
      TIMEOUT_LIMIT[nec_ir_pkg::TIMEOUT_W-1:0];

   // Configuration
   logic [nec_ir_pkg::ADDR_W-1:0]    addr_ff;

   // Input register
   logic                             s1_valid_ff;
   nec_ir_pkg::cmd_type              s1_cmd_ff;
   logic [nec_ir_pkg::WIDTH_W-1:0]   s1_width_ff;

   // Decoder state
   logic                             leader_ff, leader_in;
   logic                             ready_ff, ready_in;
   logic                             high_ff, high_in;
   logic [nec_ir_pkg::TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic [nec_ir_pkg::FRAME_W-1:0]   frame_ff, frame_in;
   logic [nec_ir_pkg::REPEAT_W-1:0]  repeats_ff, repeats_in;
   logic [nec_ir_pkg::KEY_W-1:0]     key_in;

   // Result register
   logic                             rsp_valid_ff;
   logic [nec_ir_pkg::KEY_W-1:0]     rsp_key_ff;
   logic                             rsp_leader_ff;
   logic                             rsp_ready_flag_ff;
   logic [nec_ir_pkg::REPEAT_W-1:0]  rsp_repeats_ff;

   logic s2_take;
   logic s1_adv;
   logic req_take;

   logic in_zero, in_one, in_repeat, in_leader;
   logic addr_ok, cmd_ok;
   logic [nec_ir_pkg::KEY_W-1:0] frame_addr, frame_naddr, frame_cmd, frame_ncmd;

   assign s2_take  = !rsp_valid_ff || rsp_chan.ready;
   assign s1_adv   = s1_valid_ff && s2_take;
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !s1_valid_ff || s2_take;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.key_code     = rsp_key_ff;
   assign rsp_chan.leader_seen  = rsp_leader_ff;
   assign rsp_chan.frame_ready  = rsp_ready_flag_ff;
   assign rsp_chan.repeat_count = rsp_repeats_ff;

   assign in_zero   = (s1_width_ff > nec_ir_pkg::ZERO_LO) &&
                      (s1_width_ff < nec_ir_pkg::ZERO_HI);
   assign in_one    = (s1_width_ff > nec_ir_pkg::ONE_LO) &&
                      (s1_width_ff < nec_ir_pkg::ONE_HI);
   assign in_repeat = (s1_width_ff > nec_ir_pkg::REPEAT_LO) &&
                      (s1_width_ff < nec_ir_pkg::REPEAT_HI);
   assign in_leader = (s1_width_ff > nec_ir_pkg::LEADER_LO) &&
                      (s1_width_ff < nec_ir_pkg::LEADER_HI);

   assign frame_addr  = frame_ff[31:24];
   assign frame_naddr = frame_ff[23:16];
   assign frame_cmd   = frame_ff[15:8];
   assign frame_ncmd  = frame_ff[7:0];
   assign addr_ok     = (frame_addr == ~frame_naddr) && (frame_addr == addr_ff);
   assign cmd_ok      = (frame_cmd == ~frame_ncmd);

   always_comb begin
      leader_in  = leader_ff;
      ready_in   = ready_ff;
      high_in    = high_ff;
      timeout_in = timeout_ff;
      frame_in   = frame_ff;
      repeats_in = repeats_ff;
      key_in     = '0;
      case (s1_cmd_ff)
         nec_ir_pkg::CMD_TICK: begin
            if (leader_ff) begin
               high_in = 1'b0;
               if (timeout_ff == '0) begin
                  ready_in = 1'b1;
               end
               if (timeout_ff < LIMIT_TICKS) begin
                  timeout_in = timeout_ff + 1'b1;
               end else begin
                  leader_in  = 1'b0;
                  timeout_in = '0;
               end
            end
         end
         nec_ir_pkg::CMD_RISE: begin
            high_in = 1'b1;
         end
         nec_ir_pkg::CMD_FALL: begin
            high_in = 1'b0;
            if (high_ff) begin
               if (leader_ff) begin
                  if (in_zero) begin
                     frame_in = {frame_ff[nec_ir_pkg::FRAME_W-2:0], 1'b0};
                  end else if (in_one) begin
                     frame_in = {frame_ff[nec_ir_pkg::FRAME_W-2:0], 1'b1};
                  end else if (in_repeat) begin
                     repeats_in = repeats_ff + 1'b1;
                     timeout_in = '0;
                  end
               end else if (in_leader) begin
                  leader_in  = 1'b1;
                  repeats_in = '0;
               end
            end
         end
         nec_ir_pkg::CMD_SCAN: begin
            if (ready_ff) begin
               if (addr_ok && cmd_ok) begin
                  key_in = frame_cmd;
               end
               // A zero command byte counts as no key at all.
               if (!(addr_ok && cmd_ok) || (frame_cmd == '0) || !leader_ff) begin
                  ready_in   = 1'b0;
                  repeats_in = '0;
               end
               if (addr_ok && cmd_ok && (frame_cmd != '0)) begin
                  leader_in  = 1'b0;
                  ready_in   = 1'b0;
                  high_in    = 1'b0;
                  timeout_in = '0;
               end
            end
         end
         default: begin
            high_in = high_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         leader_ff    <= 1'b0;
         ready_ff     <= 1'b0;
         high_ff      <= 1'b0;
         timeout_ff   <= '0;
         frame_ff     <= '0;
         repeats_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            addr_ff <= csr_wr_data;
         end
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (s2_take) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_adv) begin
            leader_ff  <= leader_in;
            ready_ff   <= ready_in;
            high_ff    <= high_in;
            timeout_ff <= timeout_in;
            frame_ff   <= frame_in;
            repeats_ff <= repeats_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff   <= nec_ir_pkg::cmd_type'(req_chan.cmd);
         s1_width_ff <= req_chan.pulse_width;
      end
      if (s1_adv) begin
         rsp_key_ff        <= key_in;
         rsp_leader_ff     <= leader_in;
         rsp_ready_flag_ff <= ready_in;
         rsp_repeats_ff    <= repeats_in;
      end
   end

`ifndef SYNTH
   // A delivered key always leaves the decoder disarmed with nothing pending.
   a_key_clears_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_key_ff != '0) |-> !rsp_leader_ff && !rsp_ready_flag_ff)
      else $error("key delivered while status still set");

   // The timeout counter never runs past its limit.
   a_timeout_bound: assert property (@(posedge clock) disable iff (reset)
      timeout_ff <= LIMIT_TICKS)
      else $error("timeout counter beyond limit");

   // A scan with no frame pending yields no key.
   a_scan_idle: assert property (@(posedge clock) disable iff (reset)
      s1_adv && (s1_cmd_ff == nec_ir_pkg::CMD_SCAN) && !ready_ff
      |=> rsp_valid_ff && (rsp_key_ff == '0))
      else $error("key produced without a pending frame");

   // A tick never arms the receiver.
   a_tick_no_arm: assert property (@(posedge clock) disable iff (reset)
      s1_adv && (s1_cmd_ff == nec_ir_pkg::CMD_TICK) && !leader_ff |=> !leader_ff)
      else $error("tick armed the receiver");

   // Reset empties both registers of the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire
